// File: rtl/egt_pkg.sv
// Shared types, constants and register codes for the elliptical Gaussian uv taper.
package egt_pkg;

  // Field widths
  localparam int ROW_W      = 9;
  localparam int PART_W     = 32;
  localparam int WEIGHT_W   = 17;
  localparam int ANGLE_W    = 16;
  localparam int COEF_W     = 32;
  localparam int COEF_HALF_W = 16;
  localparam int RADIUS_W   = 20;

  // Parameter defaults
  localparam int GRID_SIZE_DEF      = 512;
  localparam int EXP_TABLE_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_COEFF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_COEFF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_RADIUS_SQ = 3'd5;

  // Exponent argument: Q6.16, capped at 32.0
  localparam int X_W = 22;
  localparam logic [X_W-1:0] X_CAP = 22'h20_0000;
  // Squared magnitudes at or above this many bits always saturate a nonzero term
  localparam int SQ_LOW_W = 37;

  // log2(e) in Q.16 and rounding constants
  localparam int LOG2E_W = 17;
  localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
  localparam int ROUND_HALF_Q16 = 32768;
  // Shift counts at or above this value give a zero weight
  localparam int K_LIMIT = 17;
  // Weight shift is 14 + k; the rounding form shifts by 13 + k first
  localparam int W_SHIFT_BASE = 13;
  localparam int SH_W = 5;

  // Mantissa of 2^(-f), Q.30
  localparam int M_FRAC_W = 30;
  localparam int M_W      = 31;
  localparam logic [M_W-1:0] M_ONE   = 31'h4000_0000;
  localparam logic [M_W-1:0] M_ROUND = 31'h2000_0000;
  localparam int EXP_STEPS_MAX = 12;
  // 2^(-2^-j) in Q.30, j = 1..12
  localparam logic [M_FRAC_W-1:0] EXP_STEP [0:EXP_STEPS_MAX-1] = '{
    30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
    30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
    30'd1072289173, 30'd1073015252, 30'd1073378476, 30'd1073560135
  };

  // Pipeline and queue sizes
  localparam int FRONT_STAGES = 6;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Configuration register set
  typedef struct packed {
    logic signed [ANGLE_W-1:0] cos_angle;
    logic signed [ANGLE_W-1:0] sin_angle;
    logic [COEF_W-1:0]         major_coeff;
    logic [COEF_W-1:0]         minor_coeff;
    logic                      blank_enable;
    logic [RADIUS_W-1:0]       blank_radius_sq;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cos_angle:       16'sd6813,
    sin_angle:       -16'sd32051,
    major_coeff:     32'd65536,
    minor_coeff:     32'd65536,
    blank_enable:    1'b0,
    blank_radius_sq: 20'd524288
  };

  // Sample parts carried alongside the weight computation
  typedef struct packed {
    logic signed [PART_W-1:0] vis_real;
    logic signed [PART_W-1:0] vis_imag;
  } parts_t;

  // Input item
  typedef struct packed {
    logic [ROW_W-1:0]         grid_row;
    logic [ROW_W-1:0]         grid_col;
    logic signed [PART_W-1:0] vis_real;
    logic signed [PART_W-1:0] vis_imag;
  } vis_item_t;

  // Result item
  typedef struct packed {
    logic signed [PART_W-1:0] tapered_real;
    logic signed [PART_W-1:0] tapered_imag;
    logic [WEIGHT_W-1:0]      taper_weight;
  } taper_item_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [X_W-1:0] x;
    logic           blank;
    parts_t         parts;
  } work_item_t;

endpackage

// File: rtl/egt_stream_if.sv
// Valid/ready stream channel carrying one item of type T.
interface egt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/elliptical_gaussian_uv_taper.sv
// Elliptical Gaussian uv taper: one sample per cycle while the queue has room; an item
// passes 6 front stages, the queue register and EXP_TABLE_BITS + 5 back stages. The back
// depth is set by the exponential, which spends one multiply stage per table-index bit.
// A four-entry queue lets the front keep accepting while the output is held. Configuration
// writes take effect at once and should only be issued while no item is in flight.
module elliptical_gaussian_uv_taper #(
  parameter int GRID_SIZE      = egt_pkg::GRID_SIZE_DEF,
  parameter int EXP_TABLE_BITS = egt_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [egt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [egt_pkg::CFG_DATA_W-1:0]   cfg_data,
  egt_stream_if.sink                       vis,
  egt_stream_if.source                     tapered
);
  import egt_pkg::*;

  cfg_t cfg;

  egt_stream_if #(.T(work_item_t)) work_pre ();
  egt_stream_if #(.T(work_item_t)) work_post ();

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_COS_ANGLE:       cfg.cos_angle       <= cfg_data[ANGLE_W-1:0];
        CFG_SIN_ANGLE:       cfg.sin_angle       <= cfg_data[ANGLE_W-1:0];
        CFG_MAJOR_COEFF:     cfg.major_coeff     <= cfg_data[COEF_W-1:0];
        CFG_MINOR_COEFF:     cfg.minor_coeff     <= cfg_data[COEF_W-1:0];
        CFG_BLANK_ENABLE:    cfg.blank_enable    <= cfg_data[0];
        CFG_BLANK_RADIUS_SQ: cfg.blank_radius_sq <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  egt_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .vis  (vis),
    .work (work_pre)
  );

  egt_fifo u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (work_pre),
    .pop  (work_post)
  );

  egt_back #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .work    (work_post),
    .tapered (tapered)
  );

endmodule

// File: rtl/egt_front.sv
// Front: accept samples, rotate coordinates, classify blanking, form the exponent argument.
module egt_front #(
  parameter int GRID_SIZE = egt_pkg::GRID_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  egt_pkg::cfg_t cfg,
  egt_stream_if.sink    vis,
  egt_stream_if.source  work
);
  import egt_pkg::*;

  localparam int GRID_LOG = $clog2(GRID_SIZE);
  localparam int CW       = ((GRID_LOG > ROW_W) ? GRID_LOG : ROW_W) + 2;
  localparam int HALF     = GRID_SIZE / 2;
  localparam int PW       = CW + ANGLE_W;
  localparam int M8_W     = PW - 5;
  localparam int SQ_W     = 2 * M8_W;
  localparam int R2_W     = 2 * CW + 1;
  localparam int HI_W     = SQ_LOW_W + COEF_HALF_W;
  localparam int NS       = FRONT_STAGES;

  logic              en;
  logic [1:NS]       valid_q;
  parts_t            part_q [1:NS];
  logic              blank_q [2:NS];

  // Stage 1 signals
  logic signed [CW-1:0]   u_c, v_c;
  logic signed [2*CW-1:0] uu_c, vv_c;
  logic signed [PW-1:0]   p_uc, p_vs, p_us, p_vc;
  logic [2*CW-1:0]        uu, vv;

  // Stage 2 signals
  logic signed [PW:0]  umaj_c, umin_c;
  logic [PW:0]         mag_maj_c, mag_min_c;
  logic [PW+1:0]       rnd_maj_c, rnd_min_c;
  logic [R2_W-1:0]     r2_c;
  logic [M8_W-1:0]     m8_maj, m8_min;

  // Stage 3 and 4 signals
  logic [SQ_W-1:0]     sq_maj, sq_min;
  logic [HI_W-1:0]     lo_prod_maj_c, lo_prod_min_c;
  logic [HI_W-1:0]     hi_maj, hi_min;
  logic [SQ_LOW_W-1:0] lo_maj, lo_min;
  logic                sat_maj, sat_min;

  // Stage 5 and 6 signals
  logic [HI_W:0]       term_maj_c, term_min_c;
  logic [X_W-1:0]      t_maj, t_min;
  logic [X_W:0]        xs_c;
  logic [X_W-1:0]      x_q;

  // Advance the whole pipeline unless the last item cannot enter the queue
  assign en        = !valid_q[NS] || work.ready;
  assign vis.ready = en;

  // Centered coordinates: u points up the rows, v along the columns
  assign u_c  = CW'(HALF) - {{(CW-ROW_W){1'b0}}, vis.data.grid_row};
  assign v_c  = {{(CW-ROW_W){1'b0}}, vis.data.grid_col} - CW'(HALF);
  assign uu_c = u_c * u_c;
  assign vv_c = v_c * v_c;

  // Rotated axes, magnitudes rounded half up to Q.8, and the blanking test
  assign umaj_c    = p_uc - p_vs;
  assign umin_c    = p_us + p_vc;
  assign mag_maj_c = unsigned'(umaj_c[PW] ? -umaj_c : umaj_c);
  assign mag_min_c = unsigned'(umin_c[PW] ? -umin_c : umin_c);
  assign rnd_maj_c = {1'b0, mag_maj_c} + (PW+2)'(64);
  assign rnd_min_c = {1'b0, mag_min_c} + (PW+2)'(64);
  assign r2_c      = {1'b0, uu} + {1'b0, vv};

  // Fractional half of each coefficient product
  assign lo_prod_maj_c = sq_maj[SQ_LOW_W-1:0] * cfg.major_coeff[COEF_HALF_W-1:0];
  assign lo_prod_min_c = sq_min[SQ_LOW_W-1:0] * cfg.minor_coeff[COEF_HALF_W-1:0];

  // Axis terms and their sum
  assign term_maj_c = {1'b0, hi_maj} + (HI_W+1)'(lo_maj);
  assign term_min_c = {1'b0, hi_min} + (HI_W+1)'(lo_min);
  assign xs_c       = {1'b0, t_maj} + {1'b0, t_min};

  // Hold the valid bits in reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {vis.valid, valid_q[1:NS-1]};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: rotation products and squared radius parts
      p_uc      <= u_c * cfg.cos_angle;
      p_vs      <= v_c * cfg.sin_angle;
      p_us      <= u_c * cfg.sin_angle;
      p_vc      <= v_c * cfg.cos_angle;
      uu        <= unsigned'(uu_c);
      vv        <= unsigned'(vv_c);
      part_q[1] <= '{vis_real: vis.data.vis_real, vis_imag: vis.data.vis_imag};

      // Stage 2: rounded magnitudes and blanking decision
      m8_maj     <= rnd_maj_c[PW+1:7];
      m8_min     <= rnd_min_c[PW+1:7];
      blank_q[2] <= cfg.blank_enable && (r2_c > R2_W'(cfg.blank_radius_sq));

      // Stage 3: squares
      sq_maj <= m8_maj * m8_maj;
      sq_min <= m8_min * m8_min;

      // Stage 4: coefficient products; oversized squares saturate a nonzero term
      hi_maj  <= sq_maj[SQ_LOW_W-1:0] * cfg.major_coeff[COEF_W-1:COEF_HALF_W];
      hi_min  <= sq_min[SQ_LOW_W-1:0] * cfg.minor_coeff[COEF_W-1:COEF_HALF_W];
      lo_maj  <= lo_prod_maj_c[HI_W-1:COEF_HALF_W];
      lo_min  <= lo_prod_min_c[HI_W-1:COEF_HALF_W];
      sat_maj <= (|sq_maj[SQ_W-1:SQ_LOW_W]) && (cfg.major_coeff != '0);
      sat_min <= (|sq_min[SQ_W-1:SQ_LOW_W]) && (cfg.minor_coeff != '0);

      // Stage 5: clamp each term at the cap
      t_maj <= (sat_maj || term_maj_c > (HI_W+1)'(X_CAP)) ? X_CAP : term_maj_c[X_W-1:0];
      t_min <= (sat_min || term_min_c > (HI_W+1)'(X_CAP)) ? X_CAP : term_min_c[X_W-1:0];

      // Stage 6: exponent argument, capped at 32.0
      x_q <= (xs_c > (X_W+1)'(X_CAP)) ? X_CAP : xs_c[X_W-1:0];

      // Carry the sample parts and the blanking flag alongside
      for (int i = 2; i <= NS; i++) begin
        part_q[i] <= part_q[i-1];
      end
      for (int i = 3; i <= NS; i++) begin
        blank_q[i] <= blank_q[i-1];
      end
    end
  end

  assign work.valid = valid_q[NS];
  assign work.data  = '{x: x_q, blank: blank_q[NS], parts: part_q[NS]};

endmodule

// File: rtl/egt_fifo.sv
// Short queue between the front and the back.
module egt_fifo (
  input  logic         clk,
  input  logic         rst,
  egt_stream_if.sink   push,
  egt_stream_if.source pop
);
  import egt_pkg::*;

  work_item_t             mem [0:QUEUE_DEPTH-1];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push.ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop.valid  = (count != '0);
  assign pop.data   = mem[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  // Store an incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/egt_back.sv
// Back: base-2 exponential through a multiply chain, then scaling of both sample parts.
module egt_back #(
  parameter int EXP_TABLE_BITS = egt_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  egt_stream_if.sink   work,
  egt_stream_if.source tapered
);
  import egt_pkg::*;

  localparam int B      = EXP_TABLE_BITS;
  localparam int D      = B + 5;
  localparam int YP_W   = X_W + LOG2E_W;
  localparam int Y_W    = YP_W - 16;
  localparam int K_W    = Y_W - 16;
  localparam int PROD_W = PART_W + WEIGHT_W;
  localparam int RW     = PROD_W - 16;
  localparam logic [RW-1:0] NEG_MAX = RW'(64'h8000_0000);
  localparam logic [RW-1:0] POS_MAX = RW'(64'h7FFF_FFFF);

  logic            en;
  logic [0:D-1]    valid_q;
  parts_t          part_q [0:B+2];

  // Stage 0: Q.16 base-2 exponent
  logic [YP_W-1:0] yp_c;
  logic [Y_W-1:0]  y_q;
  logic            blank0_q;

  // Stage 1: integer shift and table index
  logic [15:0]     f_c;
  logic [K_W-1:0]  k_c;
  logic [16:0]     idx_sum_c;
  logic [B:0]      idx_full_c;
  logic [K_W:0]    k2_c;
  logic            zero_c;
  logic [B-1:0]    idx_q  [1:B];
  logic [SH_W-1:0] kk_q   [1:B+1];
  logic            zero_q [1:B+1];

  // Mantissa chain
  logic [M_W-1:0]  m_q [1:B];

  // Weight and scaling
  logic [SH_W-1:0]     sh_c;
  logic [M_W-1:0]      t_c;
  logic [M_W-1:0]      wr_c;
  logic [WEIGHT_W-1:0] w_q;
  logic [WEIGHT_W-1:0] w2_q;
  logic [PART_W-1:0]   mag_re_c, mag_im_c;
  logic [PROD_W-1:0]   prod_re_q, prod_im_q;
  logic                neg_re_q, neg_im_q;
  taper_item_t         out_q;

  // Round at bit 16, clamp, and restore the sign
  function automatic logic [PART_W-1:0] finish_part(input logic [PROD_W-1:0] prod,
                                                    input logic neg);
    logic [PROD_W-1:0] s;
    logic [RW-1:0]     r;
    s = prod + PROD_W'(ROUND_HALF_Q16);
    r = s[PROD_W-1:16];
    if (neg) begin
      if (r > NEG_MAX) begin
        r = NEG_MAX;
      end
      return PART_W'(-r);
    end else begin
      if (r > POS_MAX) begin
        r = POS_MAX;
      end
      return r[PART_W-1:0];
    end
  endfunction

  // Advance unless the output register holds an untaken item
  assign en         = !valid_q[D-1] || tapered.ready;
  assign work.ready = en;

  // Exponent scaled by log2(e), rounded half up
  assign yp_c = YP_W'(work.data.x) * YP_W'(LOG2E_Q16) + YP_W'(ROUND_HALF_Q16);

  // Split into shift and fraction; a rounded index of full scale wraps into the shift
  assign f_c        = y_q[15:0];
  assign k_c        = y_q[Y_W-1:16];
  assign idx_sum_c  = {1'b0, f_c} + 17'(1 << (15 - B));
  assign idx_full_c = idx_sum_c[16:16-B];
  assign k2_c       = {1'b0, k_c} + (K_W+1)'(idx_full_c[B]);
  assign zero_c     = blank0_q || (k2_c >= (K_W+1)'(K_LIMIT));

  // Weight: mantissa shifted right by 14 + k, rounded half up
  assign sh_c = SH_W'(W_SHIFT_BASE) + kk_q[B+1];
  assign t_c  = m_q[B] >> sh_c;
  assign wr_c = (t_c + M_W'(1)) >> 1;

  // Magnitudes of the sample parts
  assign mag_re_c = unsigned'(part_q[B+2].vis_real[PART_W-1] ? -part_q[B+2].vis_real
                                                             : part_q[B+2].vis_real);
  assign mag_im_c = unsigned'(part_q[B+2].vis_imag[PART_W-1] ? -part_q[B+2].vis_imag
                                                             : part_q[B+2].vis_imag);

  // Hold the valid bits in reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {work.valid, valid_q[0:D-2]};
    end
  end

  // Datapath stages outside the mantissa chain
  always_ff @(posedge clk) begin
    if (en) begin
      y_q       <= yp_c[YP_W-1:16];
      blank0_q  <= work.data.blank;
      part_q[0] <= work.data.parts;

      idx_q[1]  <= idx_full_c[B] ? '0 : idx_full_c[B-1:0];
      kk_q[1]   <= k2_c[SH_W-1:0];
      zero_q[1] <= zero_c;

      w_q <= zero_q[B+1] ? '0 : wr_c[WEIGHT_W-1:0];

      prod_re_q <= PROD_W'(mag_re_c) * PROD_W'(w_q);
      prod_im_q <= PROD_W'(mag_im_c) * PROD_W'(w_q);
      neg_re_q  <= part_q[B+2].vis_real[PART_W-1];
      neg_im_q  <= part_q[B+2].vis_imag[PART_W-1];
      w2_q      <= w_q;

      out_q.tapered_real <= finish_part(prod_re_q, neg_re_q);
      out_q.tapered_imag <= finish_part(prod_im_q, neg_im_q);
      out_q.taper_weight <= w2_q;

      // Carry side data down the chain
      for (int i = 1; i <= B + 2; i++) begin
        part_q[i] <= part_q[i-1];
      end
      for (int i = 2; i <= B; i++) begin
        idx_q[i] <= idx_q[i-1];
      end
      for (int i = 2; i <= B + 1; i++) begin
        kk_q[i]   <= kk_q[i-1];
        zero_q[i] <= zero_q[i-1];
      end
    end
  end

  // Mantissa chain: one stage per index bit, most significant first
  for (genvar j = 1; j <= B; j++) begin : g_step
    logic [M_W-1:0]   m_in;
    logic [2*M_W-1:0] m_prod;

    if (j == 1) begin : g_first
      assign m_in = M_ONE;
    end else begin : g_next
      assign m_in = m_q[j-1];
    end

    assign m_prod = (2*M_W)'(m_in) * (2*M_W)'(EXP_STEP[j-1]) + (2*M_W)'(M_ROUND);

    // Multiply by 2^(-2^-j) where this index bit is set
    always_ff @(posedge clk) begin
      if (en) begin
        if (idx_q[j][B-j]) begin
          m_q[j] <= m_prod[M_FRAC_W +: M_W];
        end else begin
          m_q[j] <= m_in;
        end
      end
    end
  end

  assign tapered.valid = valid_q[D-1];
  assign tapered.data  = out_q;

endmodule

// File: tb/tb_elliptical_gaussian_uv_taper.sv
// Self-checking testbench for the elliptical Gaussian uv taper: directed and random samples.
module tb_elliptical_gaussian_uv_taper;
  import egt_pkg::*;

  localparam int HALF        = GRID_SIZE_DEF / 2;
  localparam int ROW_MAX     = (1 << ROW_W) - 1;
  localparam int TBL_BITS    = EXP_TABLE_BITS_DEF;
  localparam int LATENCY     = TBL_BITS + 12;
  localparam int IDLE_PCT    = 11;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int REPORT_CAP  = 50;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [PART_W-1:0] PART_MAX = 32'h7FFF_FFFF;
  localparam logic [PART_W-1:0] PART_MIN = 32'h8000_0000;

  localparam longint unsigned LOG2E_Q    = 94548;
  localparam longint unsigned EXP_ARG_MAX = 64'd32 << 16;
  // 2^(-2^-j) in Q.30, j = 1..12
  localparam longint unsigned NEG_POW2_STEP [0:11] = '{
    64'd759250125,  64'd902905651,  64'd984625594,  64'd1028218693,
    64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
    64'd1072289173, 64'd1073015252, 64'd1073378476, 64'd1073560135
  };

  // Register copy, weight arithmetic and the queue of tapers still owed by the block
  class taper_scoreboard;
    shortint         cos_q;
    shortint         sin_q;
    longint unsigned major_q;
    longint unsigned minor_q;
    bit              blank_on;
    longint          radius_sq;
    taper_item_t     owed_tapers[$];
    int              errors;
    int              checked;
    int              zero_w;
    int              unit_w;
    int              mid_w;

    function new();
      cos_q     = 6813;
      sin_q     = -32051;
      major_q   = 65536;
      minor_q   = 65536;
      blank_on  = 1'b0;
      radius_sq = 524288;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_COS_ANGLE:       cos_q = shortint'(value[ANGLE_W-1:0]);
        CFG_SIN_ANGLE:       sin_q = shortint'(value[ANGLE_W-1:0]);
        CFG_MAJOR_COEFF:     major_q = value;
        CFG_MINOR_COEFF:     minor_q = value;
        CFG_BLANK_ENABLE:    blank_on = value[0];
        CFG_BLANK_RADIUS_SQ: radius_sq = longint'(value[RADIUS_W-1:0]);
        default: ;
      endcase
    endfunction

    // Round the rotated coordinate to Q.8, square it and scale by the Q16.16 coefficient
    function longint unsigned axis_load(longint q15, longint unsigned coeff);
      longint unsigned mag;
      longint unsigned m8;
      longint unsigned sq;
      mag = (q15 < 0) ? -q15 : q15;
      m8  = (mag + 64) >> 7;
      sq  = m8 * m8;
      return sq * (coeff >> 16) + ((sq * (coeff & 64'hFFFF)) >> 16);
    endfunction

    // exp(-x) for x in Q.16, through 2^-(k + idx/2^TBL_BITS)
    function longint unsigned gauss_weight(longint unsigned x);
      longint unsigned y;
      longint unsigned k;
      longint unsigned f;
      longint unsigned idx;
      longint unsigned m;
      int              j;
      int              s;
      if (x > EXP_ARG_MAX) x = EXP_ARG_MAX;
      y   = (x * LOG2E_Q + 32768) >> 16;
      k   = y >> 16;
      f   = y & 64'hFFFF;
      idx = (f + (64'd1 << (15 - TBL_BITS))) >> (16 - TBL_BITS);
      if (idx >= (64'd1 << TBL_BITS)) begin
        idx = 0;
        k++;
      end
      if (k >= 17) return 0;
      m = 64'd1 << 30;
      for (j = 1; j <= TBL_BITS; j++) begin
        if (((idx >> (TBL_BITS - j)) & 1) != 0)
          m = (m * NEG_POW2_STEP[j - 1] + (64'd1 << 29)) >> 30;
      end
      s = 14 + int'(k);
      return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    // Scale the magnitude with rounding, restore the sign, saturate
    function logic [PART_W-1:0] scaled_part(logic [PART_W-1:0] raw, longint unsigned w);
      longint unsigned mag;
      longint unsigned r;
      if (raw[PART_W-1]) begin
        mag = 64'h1_0000_0000 - raw;
        r   = (mag * w + 32768) >> 16;
        if (r > 64'h8000_0000) r = 64'h8000_0000;
        return PART_W'(64'h1_0000_0000 - r);
      end
      r = (longint'(raw) * w + 32768) >> 16;
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return PART_W'(r);
    endfunction

    function taper_item_t tapered_sample(vis_item_t it);
      int              u;
      int              v;
      longint          umaj;
      longint          umin;
      longint unsigned w;
      taper_item_t     t;
      u    = HALF - int'(it.grid_row);
      v    = int'(it.grid_col) - HALF;
      umaj = longint'(u) * cos_q - longint'(v) * sin_q;
      umin = longint'(u) * sin_q + longint'(v) * cos_q;
      w    = gauss_weight(axis_load(umaj, major_q) + axis_load(umin, minor_q));
      if (blank_on && longint'(u * u + v * v) > radius_sq) w = 0;
      t.tapered_real = scaled_part(it.vis_real, w);
      t.tapered_imag = scaled_part(it.vis_imag, w);
      t.taper_weight = WEIGHT_W'(w);
      return t;
    endfunction

    function void note_sample(vis_item_t it);
      taper_item_t t;
      t = tapered_sample(it);
      if (t.taper_weight == 0) zero_w++;
      else if (t.taper_weight == 65536) unit_w++;
      else mid_w++;
      owed_tapers.push_back(t);
    endfunction

    task report(string what, logic signed [63:0] got, logic signed [63:0] want);
      errors++;
      if (errors <= REPORT_CAP)
        $display("mismatch, %s at result %0d: got %0d, expected %0d", what, checked, got, want);
    endtask

    // Compare against the oldest owed taper, field by field
    task check_taper(taper_item_t got);
      taper_item_t want;
      if (owed_tapers.size() == 0) begin
        report("result with no sample owed, weight", got.taper_weight, -1);
        return;
      end
      want = owed_tapers.pop_front();
      if (got.tapered_real !== want.tapered_real)
        report("tapered_real", got.tapered_real, want.tapered_real);
      if (got.tapered_imag !== want.tapered_imag)
        report("tapered_imag", got.tapered_imag, want.tapered_imag);
      if (got.taper_weight !== want.taper_weight)
        report("taper_weight", got.taper_weight, want.taper_weight);
      checked++;
    endtask

    task flag_leftover();
      if (owed_tapers.size() != 0)
        report("samples left without a result, count", owed_tapers.size(), 0);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  egt_stream_if #(.T(vis_item_t))   vis_ch ();
  egt_stream_if #(.T(taper_item_t)) taper_ch ();

  taper_scoreboard chk = new();

  bit steady;
  bit hold_asked;
  int quiet_cycles;
  int samples_sent;
  int settings_n;
  int writes_n;

  elliptical_gaussian_uv_taper dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .vis      (vis_ch),
    .tapered  (taper_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && taper_ch.valid && taper_ch.ready) chk.check_taper(taper_ch.data);
  end

  // Abort when no item moves on either side for too long
  always @(posedge clk) begin
    if ((vis_ch.valid && vis_ch.ready) || (taper_ch.valid && taper_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    taper_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked) begin
        hold_asked = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        taper_ch.ready <= 1'b0;
      end else begin
        taper_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic offer_vis(input vis_item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      vis_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vis_ch.valid <= 1'b1;
    vis_ch.data  <= it;
    do @(posedge clk); while (!vis_ch.ready);
    chk.note_sample(it);
    samples_sent++;
  endtask

  task automatic send_at(input int row, input int col,
                         input logic [PART_W-1:0] re, input logic [PART_W-1:0] im);
    vis_item_t it;
    it.grid_row = ROW_W'(row);
    it.grid_col = ROW_W'(col);
    it.vis_real = re;
    it.vis_imag = im;
    offer_vis(it);
  endtask

  // Stop offering and wait until every owed taper has come back
  task automatic drain_tapers();
    vis_ch.valid <= 1'b0;
    while (chk.owed_tapers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    chk.set_reg(idx, value);
    writes_n++;
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] cos_w, input logic [CFG_DATA_W-1:0] sin_w,
                               input logic [CFG_DATA_W-1:0] major_w,
                               input logic [CFG_DATA_W-1:0] minor_w,
                               input logic blank_w, input logic [CFG_DATA_W-1:0] radius_w);
    write_reg(CFG_COS_ANGLE, cos_w);
    write_reg(CFG_SIN_ANGLE, sin_w);
    write_reg(CFG_MAJOR_COEFF, major_w);
    write_reg(CFG_MINOR_COEFF, minor_w);
    write_reg(CFG_BLANK_ENABLE, {31'd0, blank_w});
    write_reg(CFG_BLANK_RADIUS_SQ, radius_w);
    settings_n++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] angle_word();
    logic [ANGLE_W-1:0] a;
    a = ANGLE_W'($urandom);
    return {{(CFG_DATA_W - ANGLE_W){a[ANGLE_W-1]}}, a};
  endfunction

  // Mostly small coefficients, so that weights across the grid are neither all 0 nor all 1
  function automatic logic [CFG_DATA_W-1:0] coeff_word();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom >> $urandom_range(8, 31);
  endfunction

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] radius;
    radius = ($urandom_range(3) == 0) ? $urandom_range(0, 524288) : $urandom_range(0, 1500);
    load_settings(angle_word(), angle_word(), coeff_word(), coeff_word(), 1'($urandom), radius);
    if ($urandom_range(1) == 1)
      write_reg(($urandom_range(1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
  endtask

  function automatic logic [PART_W-1:0] random_part();
    case ($urandom_range(7))
      0: return PART_MAX;
      1: return PART_MIN;
      2: return PART_W'($urandom_range(0, 255));
      3: return -PART_W'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  // Half the samples near the center, where weights vary, half anywhere on the grid
  function automatic vis_item_t random_vis();
    vis_item_t it;
    int        reach;
    if ($urandom_range(1) == 1) begin
      reach       = $urandom_range(1, 24);
      it.grid_row = ROW_W'(HALF - reach + int'($urandom_range(0, 2 * reach)));
      it.grid_col = ROW_W'(HALF - reach + int'($urandom_range(0, 2 * reach)));
    end else begin
      it.grid_row = ROW_W'($urandom_range(0, ROW_MAX));
      it.grid_col = ROW_W'($urandom_range(0, ROW_MAX));
    end
    it.vis_real = random_part();
    it.vis_imag = random_part();
    return it;
  endfunction

  initial begin
    int p;
    int n;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= CFG_COS_ANGLE;
    cfg_data     <= '0;
    vis_ch.valid <= 1'b0;
    vis_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unit weight at the center, steep falloff, saturated exponent at corners
    send_at(HALF, HALF, PART_MAX, PART_MIN);
    send_at(HALF, HALF, '0, '1);
    send_at(HALF, HALF + 1, PART_MAX, PART_MIN);
    send_at(HALF - 1, HALF, 32'd1, 32'hFFFF_FFFF);
    send_at(HALF + 2, HALF - 3, 32'h1234_5678, 32'hEDCB_A988);
    send_at(0, 0, PART_MAX, PART_MIN);
    send_at(ROW_MAX, ROW_MAX, PART_MAX, PART_MIN);
    send_at(0, ROW_MAX, PART_MIN, PART_MAX);
    send_at(ROW_MAX, 0, PART_MIN, PART_MAX);
    drain_tapers();

    // Flat taper with blanking: radius squared 100 keeps (6,8) and (-8,-6), drops (10,1)
    load_settings(32'sd32767, 32'd0, 32'd0, 32'd0, 1'b1, 32'd100);
    send_at(HALF, HALF, PART_MAX, PART_MIN);
    send_at(HALF - 6, HALF + 8, PART_MAX, PART_MIN);
    send_at(HALF - 10, HALF + 1, PART_MAX, PART_MIN);
    send_at(HALF + 8, HALF - 6, PART_MIN, PART_MAX);
    drain_tapers();

    // Zero radius with the most negative angles and widest coefficients: only the center stays
    load_settings(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0);
    send_at(HALF, HALF, PART_MAX, PART_MIN);
    send_at(HALF, HALF - 1, PART_MAX, PART_MIN);
    drain_tapers();

    // Quarter turn: steep major axis, flat minor axis; spare indexes must change nothing
    load_settings(32'd0, 32'sd32767, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd524288);
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    send_at(HALF, HALF + 1, PART_MAX, PART_MIN);
    send_at(HALF - 1, HALF, PART_MAX, PART_MIN);
    send_at(HALF + 5, HALF, 32'h0000_FFFF, 32'hFFFF_0001);
    drain_tapers();

    // Random phases: fresh settings each, one extreme set, one without idles,
    // one with a long output hold and one with a pause until the block is empty
    for (p = 0; p < PHASES; p++) begin
      if (p == 1)
        load_settings(32'sd32767, 32'hFFFF_8000, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd524288);
      else
        random_settings();
      steady = (p == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 40) hold_asked = 1'b1;
        if (p == 4 && n == PHASE_ITEMS / 2) drain_tapers();
        offer_vis(random_vis());
      end
      steady = 1'b0;
      drain_tapers();
    end

    repeat (2 * LATENCY) @(posedge clk);
    chk.flag_leftover();
    $display("covered %0d samples under %0d register settings (%0d writes), %0d results checked",
             samples_sent, settings_n, writes_n, chk.checked);
    $display("weights seen: %0d zero, %0d unity, %0d in between",
             chk.zero_w, chk.unit_w, chk.mid_w);
    if (chk.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
